// ===== sv/tevq_pkg.sv =====
// Shared constants, codes and types for the timed event queue.
`timescale 1ns / 1ps
package tevq_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int TIME_W = 32;
    localparam int ID_W = 16;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_ADD_FUTURE = 3'd1;
    localparam logic [2:0] CMD_REMOVE_AT = 3'd2;
    localparam logic [2:0] CMD_ADVANCE = 3'd3;
    localparam logic [2:0] CMD_DUMP_ALL = 3'd4;
    localparam logic [2:0] CMD_DUMP_AT = 3'd5;

    localparam logic [1:0] KIND_FIRED = 2'd0;
    localparam logic [1:0] KIND_DUMPED = 2'd1;
    localparam logic [1:0] KIND_END = 2'd2;

    localparam logic [1:0] STATUS_OK = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_PAST = 2'd2;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t           op;
        logic               wr_tail;
        logic [IDX_W-1:0]   tail_idx;
        logic [CNT_W-1:0]   occ;
        logic [TIME_W-1:0]  new_time;
        logic [ID_W-1:0]    new_id;
    } cell_ctrl_t;

endpackage

// ===== sv/tevq_cell.sv =====
// One slot of the sorted event chain: holds a time and id, trades with its neighbors.
`timescale 1ns / 1ps
module tevq_cell (
    input  logic                          clk,
    input  logic [tevq_pkg::IDX_W-1:0]    idx,
    input  tevq_pkg::cell_ctrl_t          ctrl,
    input  logic [tevq_pkg::TIME_W-1:0]   left_time,
    input  logic [tevq_pkg::ID_W-1:0]     left_id,
    input  logic                          left_gt,
    input  logic [tevq_pkg::TIME_W-1:0]   right_time,
    input  logic [tevq_pkg::ID_W-1:0]     right_id,
    input  logic [tevq_pkg::TIME_W-1:0]   head_time,
    input  logic [tevq_pkg::ID_W-1:0]     head_id,
    output logic [tevq_pkg::TIME_W-1:0]   slot_time,
    output logic [tevq_pkg::ID_W-1:0]     slot_id,
    output logic                          gt
);
    import tevq_pkg::*;

    logic [TIME_W-1:0] time_reg;
    logic [TIME_W-1:0] time_next;
    logic [ID_W-1:0]   id_reg;
    logic [ID_W-1:0]   id_next;
    logic              used;
    logic              at_end;
    logic              is_tail;

    assign used    = CNT_W'(idx) < ctrl.occ;
    assign at_end  = CNT_W'(idx) == ctrl.occ;
    assign gt      = used && (time_reg > ctrl.new_time);
    assign is_tail = ctrl.wr_tail && (idx == ctrl.tail_idx);

    always_comb
    begin
        time_next = time_reg;
        id_next   = id_reg;
        case (ctrl.op)
            CELL_INSERT:
            begin
                // entries later than the new one move right by one
                if (gt || at_end)
                begin
                    time_next = left_gt ? left_time : ctrl.new_time;
                    id_next   = left_gt ? left_id : ctrl.new_id;
                end
            end
            CELL_SHIFT:
            begin
                time_next = is_tail ? head_time : right_time;
                id_next   = is_tail ? head_id : right_id;
            end
            default:
            begin
                time_next = time_reg;
                id_next   = id_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        time_reg <= time_next;
        id_reg   <= id_next;
    end

    assign slot_time = time_reg;
    assign slot_id   = id_reg;

endmodule

// ===== sv/timed_event_queue.sv =====
// Timed event queue top level: command sequencer over a chain of sorted event cells.
`timescale 1ns / 1ps
// Usage:
//   A command word is taken on a rising edge with start high and busy low.
//   Results come out at most one per cycle on kind/out_time/out_id/status/last,
//   each marked by valid for exactly one cycle; the receiver cannot stall.
//   Every command ends with one end result (kind end, last high).
// Command flow:
//   add, add_future and unknown commands: end result the cycle after the
//   accept, busy stays low, so one such command can be taken every cycle.
//   advance: the current time is updated at the accept, then each due head event
//   is fired in turn, then the end result follows; busy high meanwhile.
//   remove_at, dump_all, dump_at: the chain is rotated once through all
//   occupied cells, one cell per cycle, then the end result follows.
//   Fired and scanned events follow the one-slot-per-cycle walk of the cell chain.
// Reset:
//   rst_n clears the occupancy, the current time and the sequencer; the queue
//   is empty afterwards and no result is pending.
module timed_event_queue (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [2:0]                    command,
    input  logic [tevq_pkg::TIME_W-1:0]   event_time,
    input  logic [tevq_pkg::ID_W-1:0]     event_id,
    input  logic [tevq_pkg::TIME_W-1:0]   time_value,
    output logic                          valid,
    output logic [1:0]                    kind,
    output logic [tevq_pkg::TIME_W-1:0]   out_time,
    output logic [tevq_pkg::ID_W-1:0]     out_id,
    output logic [1:0]                    status,
    output logic                          last
);
    import tevq_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ADV,
        ST_SCAN
    } state_t;

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   occ_reg, occ_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TIME_W-1:0]  cur_reg, cur_next;
    logic [TIME_W-1:0]  match_reg, match_next;
    logic [2:0]         cmd_reg, cmd_next;
    logic               valid_reg, valid_next;
    logic [1:0]         kind_reg, kind_next;
    logic [TIME_W-1:0]  out_time_reg, out_time_next;
    logic [ID_W-1:0]    out_id_reg, out_id_next;
    logic [1:0]         status_reg, status_next;
    logic               last_reg, last_next;

    cell_ctrl_t         ctrl;
    logic [TIME_W-1:0]  cell_time [QUEUE_DEPTH];
    logic [ID_W-1:0]    cell_id [QUEUE_DEPTH];
    logic               cell_gt [QUEUE_DEPTH];
    logic               full;
    logic               hit;

    assign full = occ_reg == CNT_W'(QUEUE_DEPTH);
    assign hit  = cell_time[0] == match_reg;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            logic [TIME_W-1:0] l_time, r_time;
            logic [ID_W-1:0]   l_id, r_id;
            logic              l_gt;
            if (gi == 0)
            begin : g_first
                assign l_time = '0;
                assign l_id   = '0;
                assign l_gt   = 1'b0;
            end
            else
            begin : g_inner_l
                assign l_time = cell_time[gi-1];
                assign l_id   = cell_id[gi-1];
                assign l_gt   = cell_gt[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign r_time = cell_time[gi];
                assign r_id   = cell_id[gi];
            end
            else
            begin : g_inner_r
                assign r_time = cell_time[gi+1];
                assign r_id   = cell_id[gi+1];
            end
            tevq_cell u_cell (
                .clk        (clk),
                .idx        (IDX_W'(gi)),
                .ctrl       (ctrl),
                .left_time  (l_time),
                .left_id    (l_id),
                .left_gt    (l_gt),
                .right_time (r_time),
                .right_id   (r_id),
                .head_time  (cell_time[0]),
                .head_id    (cell_id[0]),
                .slot_time  (cell_time[gi]),
                .slot_id    (cell_id[gi]),
                .gt         (cell_gt[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next    = state_reg;
        occ_next      = occ_reg;
        cnt_next      = cnt_reg;
        cur_next      = cur_reg;
        match_next    = match_reg;
        cmd_next      = cmd_reg;
        valid_next    = 1'b0;
        kind_next     = KIND_END;
        out_time_next = '0;
        out_id_next   = '0;
        status_next   = STATUS_OK;
        last_next     = 1'b0;
        ctrl.op       = CELL_HOLD;
        ctrl.wr_tail  = 1'b0;
        ctrl.tail_idx = IDX_W'(occ_reg - CNT_W'(1));
        ctrl.occ      = occ_reg;
        ctrl.new_time = event_time;
        ctrl.new_id   = event_id;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (command)
                        CMD_ADD, CMD_ADD_FUTURE:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                            if (command == CMD_ADD_FUTURE && event_time <= cur_reg)
                                status_next = STATUS_PAST;
                            else if (full)
                                status_next = STATUS_FULL;
                            else
                            begin
                                ctrl.op  = CELL_INSERT;
                                occ_next = occ_reg + CNT_W'(1);
                            end
                        end
                        CMD_ADVANCE:
                        begin
                            cur_next   = cur_reg + time_value;
                            state_next = ST_ADV;
                        end
                        CMD_REMOVE_AT, CMD_DUMP_ALL, CMD_DUMP_AT:
                        begin
                            cmd_next   = command;
                            match_next = time_value;
                            cnt_next   = occ_reg;
                            state_next = ST_SCAN;
                        end
                        default:
                        begin
                            valid_next = 1'b1;
                            last_next  = 1'b1;
                        end
                    endcase
                end
            end
            ST_ADV:
            begin
                if (occ_reg != '0 && cell_time[0] <= cur_reg)
                begin
                    valid_next    = 1'b1;
                    kind_next     = KIND_FIRED;
                    out_time_next = cell_time[0];
                    out_id_next   = cell_id[0];
                    ctrl.op       = CELL_SHIFT;
                    occ_next      = occ_reg - CNT_W'(1);
                end
                else
                begin
                    valid_next = 1'b1;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == '0)
                begin
                    valid_next = 1'b1;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // head leaves the chain; kept words go back in at the tail
                    cnt_next = cnt_reg - CNT_W'(1);
                    ctrl.op  = CELL_SHIFT;
                    if (cmd_reg == CMD_REMOVE_AT && hit)
                        occ_next = occ_reg - CNT_W'(1);
                    else
                        ctrl.wr_tail = 1'b1;
                    if (cmd_reg == CMD_DUMP_ALL || (cmd_reg == CMD_DUMP_AT && hit))
                    begin
                        valid_next    = 1'b1;
                        kind_next     = KIND_DUMPED;
                        out_time_next = cell_time[0];
                        out_id_next   = cell_id[0];
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            occ_reg      <= '0;
            cnt_reg      <= '0;
            cur_reg      <= '0;
            match_reg    <= '0;
            cmd_reg      <= CMD_ADD;
            valid_reg    <= 1'b0;
            kind_reg     <= KIND_END;
            out_time_reg <= '0;
            out_id_reg   <= '0;
            status_reg   <= STATUS_OK;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            occ_reg      <= occ_next;
            cnt_reg      <= cnt_next;
            cur_reg      <= cur_next;
            match_reg    <= match_next;
            cmd_reg      <= cmd_next;
            valid_reg    <= valid_next;
            kind_reg     <= kind_next;
            out_time_reg <= out_time_next;
            out_id_reg   <= out_id_next;
            status_reg   <= status_next;
            last_reg     <= last_next;
        end
    end

    assign busy     = state_reg != ST_IDLE;
    assign valid    = valid_reg;
    assign kind     = kind_reg;
    assign out_time = out_time_reg;
    assign out_id   = out_id_reg;
    assign status   = status_reg;
    assign last     = last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy above queue depth");

    a_fired_due: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && kind_reg == KIND_FIRED |-> out_time_reg <= cur_reg)
        else $error("fired event not yet due");

    a_last_end: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && last_reg |-> kind_reg == KIND_END)
        else $error("last word is not an end word");

    a_insert_end: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (command == CMD_ADD || command == CMD_ADD_FUTURE)
        |=> valid_reg && last_reg && !busy)
        else $error("insert did not end in one cycle");

    a_fire_pops: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && kind_reg == KIND_FIRED |-> occ_reg == $past(occ_reg) - CNT_W'(1))
        else $error("fired word without pop");

endmodule

// ===== sim/timed_event_queue_test.sv =====
// Self-checking testbench for the timed event queue: random commands, predicted reports.
`timescale 1ns / 1ps
module timed_event_queue_test;
    import tevq_pkg::*;

    localparam logic [2:0] CMD_SPARE_LO = 3'd6;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam int RANDOM_WORDS = 402;
    localparam int CALM_FIRST = 200;
    localparam int CALM_LAST = 300;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_SHOWN = 10;

    typedef struct {
        logic [2:0]        cmd;
        logic [TIME_W-1:0] etime;
        logic [ID_W-1:0]   eid;
        logic [TIME_W-1:0] tval;
    } cmd_word_t;

    typedef struct {
        logic [1:0]        kind;
        logic [TIME_W-1:0] rtime;
        logic [ID_W-1:0]   rid;
        logic [1:0]        status;
        logic              is_last;
    } event_report_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [2:0]        command = 3'd0;
    logic [TIME_W-1:0] event_time = '0;
    logic [ID_W-1:0]   event_id = '0;
    logic [TIME_W-1:0] time_value = '0;
    logic              valid;
    logic [1:0]        kind;
    logic [TIME_W-1:0] out_time;
    logic [ID_W-1:0]   out_id;
    logic [1:0]        status;
    logic              last;

    cmd_word_t     pending_words[$];
    event_report_t expected_reports[$];
    logic [TIME_W-1:0] recent_times[$];

    // predicted queue contents
    logic [TIME_W-1:0] due_time[QUEUE_DEPTH];
    logic [ID_W-1:0]   due_id[QUEUE_DEPTH];
    int                held = 0;
    logic [TIME_W-1:0] now_time = '0;

    logic took_word = 1'b0;
    int   issued = 0;
    int   quiet_cycles = 0;
    int   fail_count = 0;

    timed_event_queue DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .command    (command),
        .event_time (event_time),
        .event_id   (event_id),
        .time_value (time_value),
        .valid      (valid),
        .kind       (kind),
        .out_time   (out_time),
        .out_id     (out_id),
        .status     (status),
        .last       (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic void push_report(input logic [1:0] k, input logic [TIME_W-1:0] t,
                                        input logic [ID_W-1:0] id, input logic [1:0] st,
                                        input logic lst);
        event_report_t r;
        r.kind = k;
        r.rtime = t;
        r.rid = id;
        r.status = st;
        r.is_last = lst;
        expected_reports.insert(expected_reports.size(), r);
    endfunction

    // sorted insert, equal times stay in arrival order
    function automatic logic [1:0] store_event(input logic [TIME_W-1:0] t,
                                               input logic [ID_W-1:0] id);
        int pos;
        if (held >= QUEUE_DEPTH)
            return STATUS_FULL;
        pos = held;
        while (pos > 0 && due_time[pos-1] > t)
        begin
            due_time[pos] = due_time[pos-1];
            due_id[pos] = due_id[pos-1];
            pos--;
        end
        due_time[pos] = t;
        due_id[pos] = id;
        held++;
        return STATUS_OK;
    endfunction

    function automatic void predict_word(input cmd_word_t w);
        logic [1:0] st;
        int n;
        int i;
        int keep;
        st = STATUS_OK;
        case (w.cmd)
            CMD_ADD:
                st = store_event(w.etime, w.eid);
            CMD_ADD_FUTURE:
                if (w.etime <= now_time)
                    st = STATUS_PAST;
                else
                    st = store_event(w.etime, w.eid);
            CMD_REMOVE_AT:
            begin
                keep = 0;
                for (i = 0; i < held; i++)
                begin
                    if (due_time[i] != w.tval)
                    begin
                        due_time[keep] = due_time[i];
                        due_id[keep] = due_id[i];
                        keep++;
                    end
                end
                held = keep;
            end
            CMD_ADVANCE:
            begin
                now_time = now_time + w.tval;
                n = 0;
                while (n < held && due_time[n] <= now_time)
                begin
                    push_report(KIND_FIRED, due_time[n], due_id[n], STATUS_OK, 1'b0);
                    n++;
                end
                for (i = n; i < held; i++)
                begin
                    due_time[i-n] = due_time[i];
                    due_id[i-n] = due_id[i];
                end
                held = held - n;
            end
            CMD_DUMP_ALL:
                for (i = 0; i < held; i++)
                    push_report(KIND_DUMPED, due_time[i], due_id[i], STATUS_OK, 1'b0);
            CMD_DUMP_AT:
                for (i = 0; i < held; i++)
                    if (due_time[i] == w.tval)
                        push_report(KIND_DUMPED, due_time[i], due_id[i], STATUS_OK, 1'b0);
            default:
                ;
        endcase
        push_report(KIND_END, '0, '0, st, 1'b1);
    endfunction

    function automatic void queue_word(input logic [2:0] c, input logic [TIME_W-1:0] et,
                                       input logic [ID_W-1:0] id, input logic [TIME_W-1:0] tv);
        cmd_word_t w;
        w.cmd = c;
        w.etime = et;
        w.eid = id;
        w.tval = tv;
        pending_words.insert(pending_words.size(), w);
    endfunction

    // due time for an insert: mostly near the base, often a tie with a recent one
    function automatic logic [TIME_W-1:0] pick_due(input logic [TIME_W-1:0] base);
        int r;
        logic [TIME_W-1:0] t;
        r = $urandom_range(0, 99);
        if (r < 30 && recent_times.size() != 0)
            t = recent_times[$urandom_range(0, recent_times.size() - 1)];
        else if (r < 33)
            t = '0;
        else if (r < 36)
            t = '1;
        else if (r < 40)
            t = $urandom();
        else
            t = base + $urandom_range(0, 60);
        recent_times.insert(recent_times.size(), t);
        if (recent_times.size() > 8)
            void'(recent_times.pop_front());
        return t;
    endfunction

    function automatic logic [TIME_W-1:0] pick_match(input logic [TIME_W-1:0] base);
        int r;
        r = $urandom_range(0, 99);
        if (r < 75 && recent_times.size() != 0)
            return recent_times[$urandom_range(0, recent_times.size() - 1)];
        else if (r < 90)
            return base + $urandom_range(0, 60);
        return $urandom();
    endfunction

    task automatic report_failure(input string msg);
        if (fail_count < MAX_SHOWN)
            $display("%0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // driver: a new word goes out once the last one was taken
    always @(negedge clk)
    begin : drive_words
        cmd_word_t w;
        if (rst_n && (!start || took_word))
        begin
            if (pending_words.size() != 0 &&
                ((issued >= CALM_FIRST && issued < CALM_LAST) || $urandom_range(0, 99) >= 33))
            begin
                w = pending_words.pop_front();
                command <= w.cmd;
                event_time <= w.etime;
                event_id <= w.eid;
                time_value <= w.tval;
                start <= 1'b1;
                issued <= issued + 1;
            end
            else
            begin
                start <= 1'b0;
            end
        end
    end

    // monitor: check reports, then predict for the word taken at this edge
    always @(posedge clk)
    begin : watch_reports
        event_report_t want;
        cmd_word_t     w;
        took_word <= start && !busy;
        quiet_cycles <= (valid || (start && !busy)) ? 0 : quiet_cycles + 1;
        if (valid)
        begin
            if (expected_reports.size() == 0)
            begin
                report_failure($sformatf(
                    "unexpected result kind=%0d time=%h id=%h status=%0d last=%b",
                    kind, out_time, out_id, status, last));
            end
            else
            begin
                want = expected_reports.pop_front();
                if (kind !== want.kind || out_time !== want.rtime || out_id !== want.rid ||
                    status !== want.status || last !== want.is_last)
                    report_failure($sformatf({
                        "mismatch: expected kind=%0d time=%h id=%h status=%0d last=%b, ",
                        "got kind=%0d time=%h id=%h status=%0d last=%b"},
                        want.kind, want.rtime, want.rid, want.status, want.is_last,
                        kind, out_time, out_id, status, last));
            end
        end
        if (start && !busy)
        begin
            w.cmd = command;
            w.etime = event_time;
            w.eid = event_id;
            w.tval = time_value;
            predict_word(w);
        end
    end

    initial
    begin : run_test
        logic [TIME_W-1:0] gen_now;
        cmd_word_t w;
        int i;
        int roll;

        // directed: past insert, extremes, fill to full, refused inserts, dumps, remove, unknown commands, wrap
        queue_word(CMD_ADD_FUTURE, 32'd0, 16'h1111, $urandom());
        queue_word(CMD_ADD, 32'd0, 16'h0000, $urandom());
        queue_word(CMD_ADD, 32'hFFFF_FFFF, 16'hFFFF, $urandom());
        for (i = 0; i < 14; i++)
            queue_word(CMD_ADD, 32'd100 + (i % 4) * 10, 16'(i + 1), $urandom());
        queue_word(CMD_ADD, 32'd50, 16'hAAAA, $urandom());
        queue_word(CMD_ADD_FUTURE, 32'd200, 16'h5555, $urandom());
        queue_word(CMD_DUMP_ALL, $urandom(), ID_W'($urandom()), $urandom());
        queue_word(CMD_DUMP_AT, $urandom(), ID_W'($urandom()), 32'd110);
        queue_word(CMD_REMOVE_AT, $urandom(), ID_W'($urandom()), 32'd110);
        queue_word(CMD_SPARE_LO, $urandom(), ID_W'($urandom()), $urandom());
        queue_word(CMD_SPARE_HI, $urandom(), ID_W'($urandom()), $urandom());
        queue_word(CMD_ADVANCE, $urandom(), ID_W'($urandom()), 32'hFFFF_FFFF);
        queue_word(CMD_ADVANCE, $urandom(), ID_W'($urandom()), 32'd2);
        queue_word(CMD_ADD_FUTURE, 32'd1, 16'h2222, $urandom());
        gen_now = 32'd1;

        for (i = 0; i < RANDOM_WORDS; i++)
        begin
            w.cmd = CMD_ADD;
            w.etime = $urandom();
            w.eid = ID_W'($urandom());
            w.tval = $urandom();
            roll = $urandom_range(0, 99);
            if (roll < 40)
            begin
                w.etime = pick_due(gen_now);
            end
            else if (roll < 50)
            begin
                w.cmd = CMD_ADD_FUTURE;
                w.etime = pick_due(gen_now - 20);
            end
            else if (roll < 65)
            begin
                w.cmd = CMD_ADVANCE;
                if ($urandom_range(0, 19) != 0)
                    w.tval = $urandom_range(0, 40);
            end
            else if (roll < 73)
            begin
                w.cmd = CMD_DUMP_ALL;
            end
            else if (roll < 81)
            begin
                w.cmd = CMD_DUMP_AT;
                w.tval = pick_match(gen_now);
            end
            else if (roll < 89)
            begin
                w.cmd = CMD_REMOVE_AT;
                w.tval = pick_match(gen_now);
            end
            else if (roll < 96)
            begin
                w.cmd = 3'($urandom_range(0, 7));
            end
            else
            begin
                w.cmd = ($urandom_range(0, 1) != 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
            end
            if (w.cmd == CMD_ADVANCE)
                gen_now = gen_now + w.tval;
            pending_words.insert(pending_words.size(), w);
        end

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        while ((pending_words.size() != 0 || start || expected_reports.size() != 0) &&
               quiet_cycles < STALL_LIMIT)
            @(negedge clk);
        if (quiet_cycles < STALL_LIMIT)
            repeat (DRAIN_CYCLES) @(negedge clk);
        if (quiet_cycles >= STALL_LIMIT)
            $display("watchdog: no word taken and no result for %0d cycles, %0d results pending",
                     quiet_cycles, expected_reports.size());

        if (quiet_cycles < STALL_LIMIT && fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
sv/tevq_pkg.sv
sv/tevq_cell.sv
sv/timed_event_queue.sv
sim/timed_event_queue_test.sv
